### rtl/core/sdcs_pkg.sv
// package for the servo drive command shaper: command and controlword codes,
// config register indexes and reset values, result layout, helper functions
// no dependencies
`default_nettype none

package sdcs_pkg;

  // command codes carried in tuser
  localparam logic [3:0] CMD_TICK        = 4'd0;
  localparam logic [3:0] CMD_VELOCITY    = 4'd1;
  localparam logic [3:0] CMD_POSITION    = 4'd2;
  localparam logic [3:0] CMD_TORQUE      = 4'd3;
  localparam logic [3:0] CMD_ESTOP       = 4'd4;
  localparam logic [3:0] CMD_ENABLE      = 4'd5;
  localparam logic [3:0] CMD_DISABLE     = 4'd6;
  localparam logic [3:0] CMD_CLEAR_FAULT = 4'd7;
  localparam logic [3:0] CMD_SET_MODE    = 4'd8;

  // active mode
  localparam logic [1:0] AM_VELOCITY = 2'd0;
  localparam logic [1:0] AM_POSITION = 2'd1;
  localparam logic [1:0] AM_TORQUE   = 2'd2;

  // controlwords
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
  localparam logic [15:0] CW_QUICK_STOP  = 16'h0002;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

  // statusword decoding
  localparam logic [15:0] SW_FAULT       = 16'h0008;
  localparam logic [15:0] SW_MASK        = 16'h006F;
  localparam logic [15:0] SW_READY       = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED  = 16'h0027;

  // reported drive state
  localparam logic [2:0] DS_NOT_READY   = 3'd0;
  localparam logic [2:0] DS_READY       = 3'd1;
  localparam logic [2:0] DS_SWITCHED_ON = 3'd2;
  localparam logic [2:0] DS_ENABLED     = 3'd3;
  localparam logic [2:0] DS_FAULT       = 3'd4;

  // enable sequence phases
  localparam logic [2:0] PH_FAULT_CHECK = 3'd0;
  localparam logic [2:0] PH_SHUTDOWN    = 3'd1;
  localparam logic [2:0] PH_SWITCH_ON   = 3'd2;
  localparam logic [2:0] PH_ENABLE_OP   = 3'd3;
  localparam logic [2:0] PH_DONE        = 3'd4;

  localparam int unsigned TICK_DIV_W = 4;
  localparam logic [TICK_DIV_W-1:0] ENABLE_TICK_DIVIDER = TICK_DIV_W'(10);

  // config register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_CODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_CODE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRQ_CODE     = 3'd7;

  // config reset values
  localparam logic [15:0] RST_MAX_VELOCITY = 16'd3000;
  localparam logic [14:0] RST_MAX_TORQUE   = 15'd1000;
  localparam logic [14:0] RST_RAMP_STEP    = 15'd10;
  localparam logic [30:0] RST_STEP_LIMIT   = 31'd1000;
  localparam logic [23:0] RST_GEAR_RATIO   = 24'd65536;
  localparam logic [6:0]  RST_VEL_CODE     = 7'd9;
  localparam logic [6:0]  RST_POS_CODE     = 7'd8;
  localparam logic [6:0]  RST_TRQ_CODE     = 7'd10;

  // result item, last field in the lowest bits, padded to 14 bytes
  typedef struct packed {
    logic [2:0]         pad;
    logic [2:0]         drive_state;
    logic               accepted;
    logic               recovering;
    logic               drive_enabled;
    logic signed [31:0] velocity_command;
    logic signed [31:0] position_command;
    logic signed [15:0] torque_command;
    logic [6:0]         operation_mode;
    logic [15:0]        controlword;
  } result_t;

  // apply a sign to a magnitude and saturate to 32 bits signed
  function automatic logic [31:0] sign_sat32(input logic neg, input logic [39:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 40'h0080000000) ? 32'h80000000 : 32'(-mag[31:0]);
    end else begin
      r = (mag > 40'h007FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] decode_state(input logic [15:0] sw);
    logic [15:0] st;
    logic [2:0]  ds;
    st = sw & SW_MASK;
    if ((sw & SW_FAULT) != 16'd0) ds = DS_FAULT;
    else if (st == SW_OP_ENABLED) ds = DS_ENABLED;
    else if (st == SW_SWITCHED_ON) ds = DS_SWITCHED_ON;
    else if (st == SW_READY) ds = DS_READY;
    else ds = DS_NOT_READY;
    return ds;
  endfunction

endpackage

`default_nettype wire

### rtl/core/servo_drive_command_shaper_unit.sv
// servo drive command shaper: per-item CiA402 command generation with
// config registers, a two-entry output buffer and one shared 32x24 multiplier
// depends on sdcs_pkg
`default_nettype none

// Usage
// - slave stream: tuser carries the command code (tick or one of the commands),
//   tdata the value, the drive statusword and the actual position.
// - master stream: one result per input item, the process-data words held for
//   the drive plus enabled/recovering/accepted flags and the decoded state.
// - config channel: cfg_valid_i with cfg_index_i/cfg_data_i writes one register;
//   cfg_ready_o is always high. Write only while no item is in flight.
// - output: each result is registered, in the output register or in the skid entry.
// - throughput: one item per cycle unless stalled; all state updates finish in the
//   transfer cycle, so the next item sees them at once. The path is set by the
//   shared multiplier (position scaling, velocity gear product) and the x1000 adder.
// - velocity ticks use a stored |velocity target| x gear product, refreshed on each
//   accepted velocity command and on each gear ratio write while no item transfers.
// - stall: a result the receiver does not take waits in the output register;
//   one more item is still taken into a skid entry, then s_axis_tready drops.
// - reset: config returns to its defaults, all state and held words clear,
//   active mode is velocity and the output buffer is empty.
module servo_drive_command_shaper_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] value, [47:32] statusword, [79:48] actual position
  input  wire logic [79:0]  s_axis_tdata,
  // [3:0] command code
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] controlword, [22:16] operation_mode, [38:23] torque_command,
  // [70:39] position_command, [102:71] velocity_command, [103] drive_enabled,
  // [104] recovering, [105] accepted, [108:106] drive_state, [111:109] zero
  output logic [111:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned TICK_DIV_W_L = sdcs_pkg::TICK_DIV_W;

  // config registers
  logic [15:0] max_vel_q;
  logic [14:0] max_trq_q;
  logic [14:0] ramp_step_q;
  logic [30:0] step_lim_q;
  logic [23:0] gear_q;
  logic [6:0]  vel_code_q;
  logic [6:0]  pos_code_q;
  logic [6:0]  trq_code_q;

  // state
  logic [1:0]         active_q, active_d;
  logic               enabled_q, enabled_d;
  logic               recovery_q, recovery_d;
  logic               enabling_q, enabling_d;
  logic [2:0]         phase_q, phase_d;
  logic [TICK_DIV_W_L-1:0] tick_div_q, tick_div_d;
  logic signed [15:0] trq_target_q, trq_target_d;
  logic signed [15:0] trq_cur_q, trq_cur_d;
  logic signed [31:0] pos_target_q, pos_target_d;
  logic signed [31:0] pos_cur_q, pos_cur_d;
  logic signed [16:0] vel_target_q, vel_target_d;
  logic [39:0]        vel_prod_q, vel_prod_d;
  logic [15:0]        sent_cw_q, sent_cw_d;
  logic [6:0]         sent_mode_q, sent_mode_d;
  logic signed [15:0] sent_trq_q, sent_trq_d;
  logic signed [31:0] sent_pos_q, sent_pos_d;
  logic signed [31:0] sent_vel_q, sent_vel_d;

  // output buffer
  logic                  out_valid_q;
  logic                  skid_valid_q;
  sdcs_pkg::result_t     out_q;
  sdcs_pkg::result_t     skid_q;
  sdcs_pkg::result_t     res;

  logic in_xfer;
  logic out_xfer;

  // input fields
  logic [3:0]         cmd;
  logic signed [31:0] in_value;
  logic [15:0]        in_sw;
  logic signed [31:0] in_pos;
  logic               fault;

  assign cmd      = s_axis_tuser;
  assign in_value = s_axis_tdata[31:0];
  assign in_sw    = s_axis_tdata[47:32];
  assign in_pos   = s_axis_tdata[79:48];
  assign fault    = (in_sw & sdcs_pkg::SW_FAULT) != 16'd0;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // shared multiplier: |value| x gear for commands, |velocity target| x new gear on writes
  logic        gear_wr;
  logic [31:0] val_mag;
  logic [15:0] vel_mag;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;

  assign gear_wr = cfg_valid_i && (cfg_index_i == sdcs_pkg::CFG_GEAR_RATIO);
  assign val_mag = in_value[31] ? 32'(-in_value) : in_value;
  assign vel_mag = vel_target_q[16] ? 16'(-vel_target_q) : vel_target_q[15:0];
  assign mul_a   = gear_wr ? {16'd0, vel_mag} : val_mag;
  assign mul_b   = gear_wr ? cfg_data_i[23:0] : gear_q;
  assign mul_p   = mul_a * mul_b;

  logic [31:0] pos_scaled;
  assign pos_scaled = sdcs_pkg::sign_sat32(in_value[31], mul_p[55:16]);

  // velocity tick: stored product x 1000 as shifts and subtracts
  logic [49:0] vel_x1000;
  logic [31:0] vel_scaled;
  assign vel_x1000 = {vel_prod_q, 10'd0} - {6'd0, vel_prod_q, 4'd0} - {7'd0, vel_prod_q, 3'd0};
  assign vel_scaled = sdcs_pkg::sign_sat32(vel_target_q[16], {6'd0, vel_x1000[49:16]});

  // torque ramp
  logic signed [16:0] trq_diff;
  logic [16:0]        trq_abs;
  logic signed [15:0] trq_next;
  assign trq_diff = {trq_target_q[15], trq_target_q} - {trq_cur_q[15], trq_cur_q};
  assign trq_abs  = trq_diff[16] ? 17'(-trq_diff) : trq_diff;
  always_comb begin
    if (trq_abs <= {2'd0, ramp_step_q}) begin
      trq_next = trq_target_q;
    end else if (trq_diff[16]) begin
      trq_next = trq_cur_q - $signed({1'b0, ramp_step_q});
    end else begin
      trq_next = trq_cur_q + $signed({1'b0, ramp_step_q});
    end
  end

  // position slew
  logic signed [32:0] pos_diff;
  logic [32:0]        pos_abs;
  logic signed [31:0] pos_next;
  assign pos_diff = {pos_target_q[31], pos_target_q} - {pos_cur_q[31], pos_cur_q};
  assign pos_abs  = pos_diff[32] ? 33'(-pos_diff) : pos_diff;
  always_comb begin
    if (pos_abs <= {2'd0, step_lim_q}) begin
      pos_next = pos_target_q;
    end else if (pos_diff[32]) begin
      pos_next = pos_cur_q - $signed({1'b0, step_lim_q});
    end else begin
      pos_next = pos_cur_q + $signed({1'b0, step_lim_q});
    end
  end

  // torque clamp
  logic signed [32:0] val_ext;
  logic signed [32:0] trq_lim;
  logic signed [32:0] trq_lim_n;
  logic signed [15:0] trq_clamped;
  assign val_ext   = {in_value[31], in_value};
  assign trq_lim   = {18'd0, max_trq_q};
  assign trq_lim_n = -trq_lim;
  always_comb begin
    if (val_ext > trq_lim) trq_clamped = trq_lim[15:0];
    else if (val_ext < trq_lim_n) trq_clamped = trq_lim_n[15:0];
    else trq_clamped = val_ext[15:0];
  end

  logic [15:0] sw_state;
  logic [4:0]  tick_div_inc;
  logic        ok;
  assign sw_state     = in_sw & sdcs_pkg::SW_MASK;
  assign tick_div_inc = {1'b0, tick_div_q} + 5'd1;

  always_comb begin
    active_d     = active_q;
    enabled_d    = enabled_q;
    recovery_d   = recovery_q;
    enabling_d   = enabling_q;
    phase_d      = phase_q;
    tick_div_d   = tick_div_q;
    trq_target_d = trq_target_q;
    trq_cur_d    = trq_cur_q;
    pos_target_d = pos_target_q;
    pos_cur_d    = pos_cur_q;
    vel_target_d = vel_target_q;
    vel_prod_d   = vel_prod_q;
    sent_cw_d    = sent_cw_q;
    sent_mode_d  = sent_mode_q;
    sent_trq_d   = sent_trq_q;
    sent_pos_d   = sent_pos_q;
    sent_vel_d   = sent_vel_q;
    ok           = 1'b1;

    if (in_xfer) begin
      unique case (cmd)
        sdcs_pkg::CMD_TICK: begin
          if (active_q == sdcs_pkg::AM_TORQUE || recovery_q) begin
            if (trq_diff != 17'sd0) begin
              trq_cur_d  = trq_next;
              sent_trq_d = trq_next;
              if (recovery_q && trq_next == 16'sd0) recovery_d = 1'b0;
            end
          end else if (active_q == sdcs_pkg::AM_POSITION) begin
            if (pos_diff != 33'sd0) begin
              pos_cur_d  = pos_next;
              sent_pos_d = pos_next;
              sent_cw_d  = sdcs_pkg::CW_ENABLE_OP;
            end
          end else begin
            sent_vel_d = vel_scaled;
            if (enabled_q) sent_cw_d = sdcs_pkg::CW_ENABLE_OP;
          end
          // fault seen: ramp torque down
          if (fault && !recovery_d) begin
            recovery_d   = 1'b1;
            trq_target_d = 16'sd0;
          end
          if (enabling_q) begin
            if (tick_div_q == '0) begin
              unique case (phase_q)
                sdcs_pkg::PH_FAULT_CHECK: begin
                  if (fault) sent_cw_d = sdcs_pkg::CW_FAULT_RESET;
                  else phase_d = sdcs_pkg::PH_SHUTDOWN;
                end
                sdcs_pkg::PH_SHUTDOWN: begin
                  sent_cw_d = sdcs_pkg::CW_SHUTDOWN;
                  if (sw_state == sdcs_pkg::SW_READY) phase_d = sdcs_pkg::PH_SWITCH_ON;
                end
                sdcs_pkg::PH_SWITCH_ON: begin
                  sent_cw_d   = sdcs_pkg::CW_SWITCH_ON;
                  sent_mode_d = vel_code_q;
                  if (sw_state == sdcs_pkg::SW_SWITCHED_ON) phase_d = sdcs_pkg::PH_ENABLE_OP;
                end
                sdcs_pkg::PH_ENABLE_OP: begin
                  sent_cw_d   = sdcs_pkg::CW_ENABLE_OP;
                  sent_mode_d = vel_code_q;
                  if (sw_state == sdcs_pkg::SW_OP_ENABLED) begin
                    enabled_d  = 1'b1;
                    enabling_d = 1'b0;
                    phase_d    = sdcs_pkg::PH_DONE;
                  end
                end
                default: begin
                  phase_d = sdcs_pkg::PH_DONE;
                end
              endcase
            end
            tick_div_d = (tick_div_inc >= {1'b0, sdcs_pkg::ENABLE_TICK_DIVIDER}) ?
                         '0 : tick_div_inc[TICK_DIV_W_L-1:0];
          end
        end
        sdcs_pkg::CMD_VELOCITY: begin
          if (!enabled_q || val_mag > {16'd0, max_vel_q}) begin
            ok = 1'b0;
          end else begin
            vel_target_d = in_value[16:0];
            vel_prod_d   = mul_p[39:0];
            if (active_q != sdcs_pkg::AM_VELOCITY) begin
              pos_target_d = in_pos;
              pos_cur_d    = in_pos;
              sent_pos_d   = in_pos;
              sent_mode_d  = vel_code_q;
              sent_cw_d    = sdcs_pkg::CW_ENABLE_OP;
              active_d     = sdcs_pkg::AM_VELOCITY;
            end
          end
        end
        sdcs_pkg::CMD_POSITION: begin
          if (!enabled_q) begin
            ok = 1'b0;
          end else begin
            pos_target_d = pos_scaled;
            if (active_q != sdcs_pkg::AM_POSITION) begin
              vel_target_d = 17'sd0;
              vel_prod_d   = '0;
              sent_vel_d   = 32'sd0;
              sent_mode_d  = pos_code_q;
              sent_cw_d    = sdcs_pkg::CW_ENABLE_OP;
              active_d     = sdcs_pkg::AM_POSITION;
              pos_cur_d    = in_pos;
            end
          end
        end
        sdcs_pkg::CMD_TORQUE: begin
          if (!enabled_q || fault) begin
            ok = 1'b0;
          end else begin
            trq_target_d = trq_clamped;
            if (active_q != sdcs_pkg::AM_TORQUE) begin
              vel_target_d = 17'sd0;
              vel_prod_d   = '0;
              sent_vel_d   = 32'sd0;
              pos_target_d = in_pos;
              pos_cur_d    = in_pos;
              sent_pos_d   = in_pos;
              sent_mode_d  = trq_code_q;
              sent_cw_d    = sdcs_pkg::CW_ENABLE_OP;
              active_d     = sdcs_pkg::AM_TORQUE;
            end
          end
        end
        sdcs_pkg::CMD_ESTOP: begin
          recovery_d   = 1'b1;
          trq_target_d = 16'sd0;
          sent_vel_d   = 32'sd0;
          sent_cw_d    = sdcs_pkg::CW_QUICK_STOP;
        end
        sdcs_pkg::CMD_ENABLE: begin
          phase_d    = sdcs_pkg::PH_FAULT_CHECK;
          enabled_d  = 1'b0;
          enabling_d = 1'b1;
          tick_div_d = '0;
        end
        sdcs_pkg::CMD_DISABLE: begin
          enabled_d    = 1'b0;
          enabling_d   = 1'b0;
          recovery_d   = 1'b0;
          trq_cur_d    = 16'sd0;
          trq_target_d = 16'sd0;
          vel_target_d = 17'sd0;
          vel_prod_d   = '0;
          pos_target_d = 32'sd0;
          sent_cw_d    = sdcs_pkg::CW_SHUTDOWN;
          sent_vel_d   = 32'sd0;
          sent_trq_d   = 16'sd0;
          sent_pos_d   = 32'sd0;
        end
        sdcs_pkg::CMD_CLEAR_FAULT: begin
          sent_cw_d  = sdcs_pkg::CW_FAULT_RESET;
          recovery_d = 1'b0;
        end
        sdcs_pkg::CMD_SET_MODE: begin
          if (in_value[31:2] == 30'd0 && in_value[1:0] != 2'd3) active_d = in_value[1:0];
          else ok = 1'b0;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end else if (gear_wr) begin
      // new gear ratio: refresh the stored velocity product
      vel_prod_d = mul_p[39:0];
    end
  end

  always_comb begin
    res.pad              = '0;
    res.drive_state      = sdcs_pkg::decode_state(in_sw);
    res.accepted         = ok;
    res.recovering       = recovery_d;
    res.drive_enabled    = enabled_d;
    res.velocity_command = sent_vel_d;
    res.position_command = sent_pos_d;
    res.torque_command   = sent_trq_d;
    res.operation_mode   = sent_mode_d;
    res.controlword      = sent_cw_d;
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q   <= sdcs_pkg::RST_MAX_VELOCITY;
      max_trq_q   <= sdcs_pkg::RST_MAX_TORQUE;
      ramp_step_q <= sdcs_pkg::RST_RAMP_STEP;
      step_lim_q  <= sdcs_pkg::RST_STEP_LIMIT;
      gear_q      <= sdcs_pkg::RST_GEAR_RATIO;
      vel_code_q  <= sdcs_pkg::RST_VEL_CODE;
      pos_code_q  <= sdcs_pkg::RST_POS_CODE;
      trq_code_q  <= sdcs_pkg::RST_TRQ_CODE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdcs_pkg::CFG_MAX_VELOCITY: max_vel_q   <= cfg_data_i[15:0];
        sdcs_pkg::CFG_MAX_TORQUE:   max_trq_q   <= cfg_data_i[14:0];
        sdcs_pkg::CFG_RAMP_STEP:    ramp_step_q <= cfg_data_i[14:0];
        sdcs_pkg::CFG_STEP_LIMIT:   step_lim_q  <= cfg_data_i[30:0];
        sdcs_pkg::CFG_GEAR_RATIO:   gear_q      <= cfg_data_i[23:0];
        sdcs_pkg::CFG_VEL_CODE:     vel_code_q  <= cfg_data_i[6:0];
        sdcs_pkg::CFG_POS_CODE:     pos_code_q  <= cfg_data_i[6:0];
        sdcs_pkg::CFG_TRQ_CODE:     trq_code_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= sdcs_pkg::AM_VELOCITY;
      enabled_q    <= 1'b0;
      recovery_q   <= 1'b0;
      enabling_q   <= 1'b0;
      phase_q      <= sdcs_pkg::PH_FAULT_CHECK;
      tick_div_q   <= '0;
      trq_target_q <= '0;
      trq_cur_q    <= '0;
      pos_target_q <= '0;
      pos_cur_q    <= '0;
      vel_target_q <= '0;
      vel_prod_q   <= '0;
      sent_cw_q    <= '0;
      sent_mode_q  <= '0;
      sent_trq_q   <= '0;
      sent_pos_q   <= '0;
      sent_vel_q   <= '0;
    end else begin
      active_q     <= active_d;
      enabled_q    <= enabled_d;
      recovery_q   <= recovery_d;
      enabling_q   <= enabling_d;
      phase_q      <= phase_d;
      tick_div_q   <= tick_div_d;
      trq_target_q <= trq_target_d;
      trq_cur_q    <= trq_cur_d;
      pos_target_q <= pos_target_d;
      pos_cur_q    <= pos_cur_d;
      vel_target_q <= vel_target_d;
      vel_prod_q   <= vel_prod_d;
      sent_cw_q    <= sent_cw_d;
      sent_mode_q  <= sent_mode_d;
      sent_trq_q   <= sent_trq_d;
      sent_pos_q   <= sent_pos_d;
      sent_vel_q   <= sent_vel_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (!out_valid_q || m_axis_tready) out_valid_q <= 1'b1;
        else skid_valid_q <= 1'b1;
      end else if (out_xfer) begin
        if (skid_valid_q) skid_valid_q <= 1'b0;
        else out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (!out_valid_q || m_axis_tready) out_q <= res;
      else skid_q <= res;
    end else if (out_xfer && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
